>>> rtl/ppe_pkg.sv
// ---------------------------------------------------------------------------
// ppe_pkg
// shared types and constants of the path profile engine
// ---------------------------------------------------------------------------
package ppe_pkg;

  // sequencer states
  typedef enum logic [5:0] {
    ST_IDLE,
    ST_SHORT,
    ST_ARC_RD, ST_ARC_CAP, ST_ARC_M0, ST_ARC_M1, ST_ARC_SQ, ST_ARC_WR,
    ST_DER_RA, ST_DER_RB, ST_DER_CB, ST_DER_DX, ST_DER_DY, ST_DER_WR,
    ST_CRV_RA, ST_CRV_RB, ST_CRV_RI, ST_CRV_CI, ST_CRV_DX, ST_CRV_DY,
    ST_CRV_M0, ST_CRV_M1, ST_CRV_M2, ST_CRV_M3, ST_CRV_M4, ST_CRV_SQ,
    ST_CRV_M5, ST_CRV_DV, ST_CRV_WR,
    ST_OUT_RA, ST_OUT_RB, ST_OUT_RI, ST_OUT_CI, ST_OUT_DV, ST_OUT_PRE,
    ST_OUT_NORM, ST_OUT_ROT, ST_OUT_EMIT
  } ppe_state_t;

  // result status codes
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_FEW  = 2'd1;
  localparam logic [1:0] STAT_DROP = 2'd2;

  // divider: quotient bits and saturation magnitude
  localparam int          DIV_QBITS = 31;
  localparam logic [30:0] SAT_MAG   = 31'h7FFF_FFFF;

  // square root: result bits of the 68-bit radicand
  localparam int SQRT_STEPS = 34;

  // cordic constants
  localparam int                 ATAN_DEPTH = 24;
  localparam logic signed [35:0] PI_Q30     = 36'sd3373259426;
  localparam logic signed [47:0] NORM_LIM   = 48'sh0100_0000_0000;

  localparam logic [29:0] ATAN_Q30 [ATAN_DEPTH] = '{
    30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76,
    30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
    30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
    30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
    30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F
  };

endpackage

>>> rtl/path_profile_engine.sv
// ---------------------------------------------------------------------------
// path_profile_engine
// heading, arc length, curvature and curvature rate along a loaded polyline
// ---------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------
//  in       | start / busy         | in_point_x, in_point_y, in_final_point
//  out      | out_valid (strobe)   | out_heading .. out_last_result
//
//  - a point item is taken while idle; points are written to
//    the point memories, the last-point flag launches the profile run
//  - in a run each point goes through the shared 31-step divider up to six
//    times, the 34-step square root at most twice, the cordic normalize loop
//    once and the cordic rotate loop at most once
//  - results leave one per point on a one-cycle out_valid strobe; the
//    receiver cannot stall, busy stays high until the last result is out
//  - rst_n is synchronous; it clears the sequencer and point count, the
//    memories keep their contents and need no clearing pass
//
module path_profile_engine
  import ppe_pkg::*;
#(
  parameter int MAX_POINTS        = 64,
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic               in_final_point,
  output logic               out_valid,
  output logic signed [15:0] out_heading,
  output logic        [31:0] out_arc_length,
  output logic signed [31:0] out_curvature,
  output logic signed [31:0] out_curvature_rate,
  output logic        [1:0]  out_status,
  output logic               out_last_result
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int CI = (CORDIC_ITERATIONS < ATAN_DEPTH) ? CORDIC_ITERATIONS : ATAN_DEPTH;

  // point, arc, derivative and curvature memories
  logic [31:0] x_mem   [MAX_POINTS];
  logic [31:0] y_mem   [MAX_POINTS];
  logic [31:0] arc_mem [MAX_POINTS];
  logic [31:0] fx_mem  [MAX_POINTS];
  logic [31:0] fy_mem  [MAX_POINTS];
  logic [31:0] k_mem   [MAX_POINTS];

  logic signed [31:0] x_q, y_q, fx_q, fy_q, k_q;
  logic        [31:0] arc_q;

  // control
  ppe_state_t   state_r, state_nxt;
  logic [CW-1:0] cnt_r, n_r, n_load;
  logic          drop_r, wait_r, full;
  logic [1:0]    stat_r;
  logic [AW-1:0] idx_r, ia, ib, n_m1, rd_addr;
  logic          last;
  logic          div_go, sq_go, div_done, sq_done;
  logic          load_we;

  // operand captures
  logic signed [31:0] a_x, a_y, a_fx, a_fy, a_k, b_x, b_y, b_fx, b_fy, b_k;
  logic        [31:0] a_arc, b_arc, i_arc;
  logic signed [31:0] i_fx, i_fy, i_k;
  logic signed [31:0] fx_r, fy_r, sx_r, sy_r, k_r, dk_r;

  // arc length datapath
  logic [31:0] ax_r, ay_r;
  logic [63:0] pa_r, pb_r;
  logic [34:0] arc_sum;
  logic [31:0] arc_new;

  // curvature datapath
  logic signed [63:0] p0_r, p1_r, num_r;
  logic        [32:0] q30_r;
  logic        [30:0] ux, uy;
  logic        [25:0] den;
  logic        [63:0] psum;

  // divider
  logic [63:0] div_dvd;
  logic [35:0] div_dvs;
  logic        div_sgn;
  logic signed [32:0] dnum;
  logic [32:0] dabs;
  logic [5:0]  dsh;
  logic [36:0] div_rem_r, div_trial;
  logic [35:0] div_d_r;
  logic [30:0] div_lo_r, div_q_r, div_mag;
  logic        div_ovf_r, div_neg_r, div_act_r;
  logic [4:0]  div_cnt_r;
  logic signed [31:0] div_res, div_kres;

  // square root
  logic [67:0] sq_op, sq_op_r;
  logic [36:0] sq_rem_r, sq_trial, sq_t;
  logic [33:0] sq_root_r;
  logic [5:0]  sq_cnt_r;
  logic        sq_act_r;

  // cordic
  logic signed [32:0] cdx, cdy;
  logic signed [47:0] cx_r, cy_r;
  logic signed [35:0] z_r, zr;
  logic [4:0]  it_r;
  logic        hz_r, norm_cond;
  logic signed [15:0] hd;

  // output registers
  logic               out_valid_r, out_last_r;
  logic signed [15:0] out_heading_r;
  logic        [31:0] out_arc_r;
  logic signed [31:0] out_curv_r, out_rate_r;
  logic        [1:0]  out_status_r;

  // ---------------------------------------------------------------- indexes
  assign full    = (cnt_r == CW'(MAX_POINTS));
  assign n_load  = full ? cnt_r : cnt_r + CW'(1);
  assign n_m1    = AW'(n_r - CW'(1));
  assign last    = (idx_r == n_m1);
  assign ia      = (idx_r == '0) ? '0 : idx_r - AW'(1);
  assign ib      = last ? n_m1 : idx_r + AW'(1);
  assign load_we = (state_r == ST_IDLE) && start && !full;
  assign busy    = (state_r != ST_IDLE);

  assign div_done = wait_r && !div_act_r;
  assign sq_done  = wait_r && !sq_act_r;

  // ---------------------------------------------------------------- memories
  always_ff @(posedge clk) begin
    if (load_we) begin
      x_mem[cnt_r[AW-1:0]] <= in_point_x;
    end
    x_q <= x_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (load_we) begin
      y_mem[cnt_r[AW-1:0]] <= in_point_y;
    end
    y_q <= y_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_ARC_WR) begin
      arc_mem[idx_r] <= arc_new;
    end
    arc_q <= arc_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DER_WR) begin
      fx_mem[idx_r] <= fx_r;
    end
    fx_q <= fx_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DER_WR) begin
      fy_mem[idx_r] <= fy_r;
    end
    fy_q <= fy_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_CRV_WR) begin
      k_mem[idx_r] <= k_r;
    end
    k_q <= k_mem[rd_addr];
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      drop_r      <= 1'b0;
      n_r         <= '0;
      stat_r      <= STAT_OK;
      idx_r       <= '0;
      wait_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_OUT_EMIT) || (state_r == ST_SHORT);
      if (div_go || sq_go) begin
        wait_r <= 1'b1;
      end else if (state_nxt != state_r) begin
        wait_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            if (in_final_point) begin
              n_r    <= n_load;
              stat_r <= (drop_r || full) ? STAT_DROP : STAT_OK;
              cnt_r  <= '0;
              drop_r <= 1'b0;
              idx_r  <= '0;
            end else if (full) begin
              drop_r <= 1'b1;
            end else begin
              cnt_r <= cnt_r + CW'(1);
            end
          end
        end
        ST_ARC_WR, ST_DER_WR, ST_CRV_WR, ST_OUT_EMIT: begin
          idx_r <= last ? '0 : idx_r + AW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    rd_addr   = idx_r;
    div_go    = 1'b0;
    sq_go     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start && in_final_point) begin
          state_nxt = (n_load < CW'(2)) ? ST_SHORT : ST_ARC_RD;
        end
      end
      ST_SHORT:   state_nxt = ST_IDLE;
      // arc length, one segment per point
      ST_ARC_RD:  state_nxt = ST_ARC_CAP;
      ST_ARC_CAP: state_nxt = (idx_r == '0) ? ST_ARC_WR : ST_ARC_M0;
      ST_ARC_M0:  state_nxt = ST_ARC_M1;
      ST_ARC_M1:  state_nxt = ST_ARC_SQ;
      ST_ARC_SQ: begin
        sq_go = !wait_r;
        if (sq_done) state_nxt = ST_ARC_WR;
      end
      ST_ARC_WR:  state_nxt = last ? ST_DER_RA : ST_ARC_RD;
      // first derivatives
      ST_DER_RA: begin
        rd_addr   = ia;
        state_nxt = ST_DER_RB;
      end
      ST_DER_RB: begin
        rd_addr   = ib;
        state_nxt = ST_DER_CB;
      end
      ST_DER_CB:  state_nxt = ST_DER_DX;
      ST_DER_DX: begin
        div_go = !wait_r;
        if (div_done) state_nxt = ST_DER_DY;
      end
      ST_DER_DY: begin
        div_go = !wait_r;
        if (div_done) state_nxt = ST_DER_WR;
      end
      ST_DER_WR:  state_nxt = last ? ST_CRV_RA : ST_DER_RA;
      // second derivatives and curvature
      ST_CRV_RA: begin
        rd_addr   = ia;
        state_nxt = ST_CRV_RB;
      end
      ST_CRV_RB: begin
        rd_addr   = ib;
        state_nxt = ST_CRV_RI;
      end
      ST_CRV_RI:  state_nxt = ST_CRV_CI;
      ST_CRV_CI:  state_nxt = ST_CRV_DX;
      ST_CRV_DX: begin
        div_go = !wait_r;
        if (div_done) state_nxt = ST_CRV_DY;
      end
      ST_CRV_DY: begin
        div_go = !wait_r;
        if (div_done) state_nxt = ST_CRV_M0;
      end
      ST_CRV_M0:  state_nxt = ST_CRV_M1;
      ST_CRV_M1:  state_nxt = ST_CRV_M2;
      ST_CRV_M2:  state_nxt = ST_CRV_M3;
      ST_CRV_M3:  state_nxt = ST_CRV_M4;
      ST_CRV_M4:  state_nxt = ST_CRV_SQ;
      ST_CRV_SQ: begin
        sq_go = !wait_r;
        if (sq_done) state_nxt = ST_CRV_M5;
      end
      ST_CRV_M5:  state_nxt = ST_CRV_DV;
      ST_CRV_DV: begin
        div_go = !wait_r;
        if (div_done) state_nxt = ST_CRV_WR;
      end
      ST_CRV_WR:  state_nxt = last ? ST_OUT_RA : ST_CRV_RA;
      // curvature rate, heading and result
      ST_OUT_RA: begin
        rd_addr   = ia;
        state_nxt = ST_OUT_RB;
      end
      ST_OUT_RB: begin
        rd_addr   = ib;
        state_nxt = ST_OUT_RI;
      end
      ST_OUT_RI:  state_nxt = ST_OUT_CI;
      ST_OUT_CI:  state_nxt = ST_OUT_DV;
      ST_OUT_DV: begin
        div_go = !wait_r;
        if (div_done) state_nxt = ST_OUT_PRE;
      end
      ST_OUT_PRE: state_nxt = ST_OUT_NORM;
      ST_OUT_NORM: begin
        if (hz_r) state_nxt = ST_OUT_EMIT;
        else if (!norm_cond) state_nxt = ST_OUT_ROT;
      end
      ST_OUT_ROT: begin
        if (it_r == 5'(CI - 1)) state_nxt = ST_OUT_EMIT;
      end
      ST_OUT_EMIT: state_nxt = last ? ST_IDLE : ST_OUT_RA;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- datapath
  assign arc_sum = {3'b000, a_arc} + {1'b0, sq_root_r};
  assign arc_new = (idx_r == '0) ? 32'd0 :
                   ((arc_sum[34:32] != 3'b000) ? 32'hFFFF_FFFF : arc_sum[31:0]);
  assign ux      = i_fx[31] ? 31'(-i_fx) : i_fx[30:0];
  assign uy      = i_fy[31] ? 31'(-i_fy) : i_fy[30:0];
  assign psum    = p0_r + p1_r;
  assign den     = 26'(p0_r[63:30]) + 26'd1;

  always_ff @(posedge clk) begin
    case (state_r) inside
      ST_DER_RB, ST_CRV_RB, ST_OUT_RB: begin
        a_x   <= x_q;
        a_y   <= y_q;
        a_arc <= arc_q;
        a_fx  <= fx_q;
        a_fy  <= fy_q;
        a_k   <= k_q;
      end
      ST_DER_CB, ST_CRV_RI, ST_OUT_RI: begin
        b_x   <= x_q;
        b_y   <= y_q;
        b_arc <= arc_q;
        b_fx  <= fx_q;
        b_fy  <= fy_q;
        b_k   <= k_q;
      end
      ST_CRV_CI, ST_OUT_CI: begin
        i_arc <= arc_q;
        i_fx  <= fx_q;
        i_fy  <= fy_q;
        i_k   <= k_q;
      end
      ST_ARC_CAP: begin
        b_x  <= x_q;
        b_y  <= y_q;
        ax_r <= 32'((x_q < a_x) ? (33'(a_x) - 33'(x_q)) : (33'(x_q) - 33'(a_x)));
        ay_r <= 32'((y_q < a_y) ? (33'(a_y) - 33'(y_q)) : (33'(y_q) - 33'(a_y)));
      end
      ST_ARC_M0: pa_r <= ax_r * ax_r;
      ST_ARC_M1: pb_r <= ay_r * ay_r;
      ST_ARC_WR: begin
        a_x   <= b_x;
        a_y   <= b_y;
        a_arc <= arc_new;
      end
      ST_DER_DX: if (div_done) fx_r <= div_res;
      ST_DER_DY: if (div_done) fy_r <= div_res;
      ST_CRV_DX: if (div_done) sx_r <= div_res;
      ST_CRV_DY: if (div_done) sy_r <= div_res;
      ST_CRV_M0: p0_r <= i_fx * sy_r;
      ST_CRV_M1: p1_r <= i_fy * sx_r;
      ST_CRV_M2: begin
        num_r <= p0_r - p1_r;
        p0_r  <= ux * ux;
      end
      ST_CRV_M3: p1_r  <= uy * uy;
      ST_CRV_M4: q30_r <= psum[62:30];
      ST_CRV_M5: p0_r  <= 64'(sq_root_r[21:0]) * 64'(q30_r);
      ST_CRV_DV: if (div_done) k_r <= div_kres;
      ST_OUT_DV: if (div_done) dk_r <= div_res;
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------- divider
  // (m << sh) / d over 31 quotient bits, overflow decided up front
  always_comb begin
    dnum = '0;
    dsh  = '0;
    case (state_r)
      ST_DER_DX: begin dnum = 33'(b_x) - 33'(a_x);   dsh = 6'd30; end
      ST_DER_DY: begin dnum = 33'(b_y) - 33'(a_y);   dsh = 6'd30; end
      ST_CRV_DX: begin dnum = 33'(b_fx) - 33'(a_fx); dsh = 6'd2;  end
      ST_CRV_DY: begin dnum = 33'(b_fy) - 33'(a_fy); dsh = 6'd2;  end
      ST_OUT_DV: begin dnum = 33'(b_k) - 33'(a_k);   dsh = 6'd16; end
      default: begin
      end
    endcase
    dabs = dnum[32] ? 33'(-dnum) : dnum;
    if (state_r == ST_CRV_DV) begin
      div_sgn = num_r[63];
      div_dvd = num_r[63] ? 64'(-num_r) : 64'(num_r);
      div_dvs = {den, 10'd0};
    end else begin
      div_sgn = dnum[32];
      div_dvd = 64'(dabs[31:0]) << dsh;
      div_dvs = 36'(b_arc - a_arc);
    end
  end

  assign div_trial = {div_rem_r[35:0], div_lo_r[30]};
  assign div_mag   = div_ovf_r ? SAT_MAG : div_q_r;
  assign div_res   = div_neg_r ? -$signed({1'b0, div_mag}) : $signed({1'b0, div_mag});
  assign div_kres  = div_neg_r ? (div_ovf_r ? 32'sh8000_0000 : -$signed({1'b0, div_q_r}))
                               : $signed({1'b0, div_mag});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_act_r <= 1'b0;
    end else if (div_go) begin
      div_act_r <= 1'b1;
    end else if (div_act_r && div_cnt_r == 5'(DIV_QBITS - 1)) begin
      div_act_r <= 1'b0;
    end
  end

  // a zero span with a zero numerator divides by one so the quotient is zero
  always_ff @(posedge clk) begin
    if (div_go) begin
      div_rem_r <= 37'(div_dvd[63:31]);
      div_lo_r  <= div_dvd[30:0];
      div_d_r   <= (div_dvs == '0) ? 36'd1 : div_dvs;
      div_ovf_r <= (37'(div_dvd[63:31]) >= 37'(div_dvs)) && (div_dvd != '0);
      div_neg_r <= div_sgn;
      div_q_r   <= '0;
      div_cnt_r <= '0;
    end else if (div_act_r) begin
      if (div_trial >= 37'(div_d_r)) begin
        div_rem_r <= div_trial - 37'(div_d_r);
        div_q_r   <= {div_q_r[29:0], 1'b1};
      end else begin
        div_rem_r <= div_trial;
        div_q_r   <= {div_q_r[29:0], 1'b0};
      end
      div_lo_r  <= {div_lo_r[29:0], 1'b0};
      div_cnt_r <= div_cnt_r + 5'd1;
    end
  end

  // ---------------------------------------------------------------- square root
  // floor root, two radicand bits per step
  assign sq_op    = (state_r == ST_CRV_SQ) ? {25'd0, q30_r, 10'd0} : {3'd0, 65'(pa_r) + 65'(pb_r)};
  assign sq_trial = {sq_rem_r[34:0], sq_op_r[67:66]};
  assign sq_t     = {1'b0, sq_root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_act_r <= 1'b0;
    end else if (sq_go) begin
      sq_act_r <= 1'b1;
    end else if (sq_act_r && sq_cnt_r == 6'(SQRT_STEPS - 1)) begin
      sq_act_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sq_go) begin
      sq_op_r   <= sq_op;
      sq_rem_r  <= '0;
      sq_root_r <= '0;
      sq_cnt_r  <= '0;
    end else if (sq_act_r) begin
      if (sq_trial >= sq_t) begin
        sq_rem_r  <= sq_trial - sq_t;
        sq_root_r <= {sq_root_r[32:0], 1'b1};
      end else begin
        sq_rem_r  <= sq_trial;
        sq_root_r <= {sq_root_r[32:0], 1'b0};
      end
      sq_op_r  <= {sq_op_r[65:0], 2'b00};
      sq_cnt_r <= sq_cnt_r + 6'd1;
    end
  end

  // ---------------------------------------------------------------- cordic
  // fold into right half plane, scale up, then vectoring rotations
  assign cdx       = 33'(b_x) - 33'(a_x);
  assign cdy       = 33'(b_y) - 33'(a_y);
  assign norm_cond = (cx_r < NORM_LIM) && (cy_r < NORM_LIM) && (cy_r > -NORM_LIM);
  assign zr        = (z_r + 36'sd65536) >>> 17;
  assign hd        = hz_r ? 16'sd0 :
                     (zr > 36'sd32767)  ? 16'sh7FFF :
                     (zr < -36'sd32768) ? 16'sh8000 : zr[15:0];

  always_ff @(posedge clk) begin
    case (state_r)
      ST_OUT_PRE: begin
        hz_r <= (cdx == '0) && (cdy == '0);
        it_r <= '0;
        if (cdx[32]) begin
          z_r  <= cdy[32] ? -PI_Q30 : PI_Q30;
          cx_r <= -48'(cdx);
          cy_r <= -48'(cdy);
        end else begin
          z_r  <= '0;
          cx_r <= 48'(cdx);
          cy_r <= 48'(cdy);
        end
      end
      ST_OUT_NORM: begin
        if (!hz_r && norm_cond) begin
          cx_r <= cx_r <<< 1;
          cy_r <= cy_r <<< 1;
        end
      end
      ST_OUT_ROT: begin
        if (!cy_r[47]) begin
          cx_r <= cx_r + (cy_r >>> it_r);
          cy_r <= cy_r - (cx_r >>> it_r);
          z_r  <= z_r + 36'(ATAN_Q30[it_r]);
        end else begin
          cx_r <= cx_r - (cy_r >>> it_r);
          cy_r <= cy_r + (cx_r >>> it_r);
          z_r  <= z_r - 36'(ATAN_Q30[it_r]);
        end
        it_r <= it_r + 5'd1;
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------- results
  always_ff @(posedge clk) begin
    if (state_r == ST_OUT_EMIT) begin
      out_heading_r <= hd;
      out_arc_r     <= i_arc;
      out_curv_r    <= i_k;
      out_rate_r    <= dk_r;
      out_status_r  <= stat_r;
      out_last_r    <= last;
    end else if (state_r == ST_SHORT) begin
      out_heading_r <= '0;
      out_arc_r     <= '0;
      out_curv_r    <= '0;
      out_rate_r    <= '0;
      out_status_r  <= STAT_FEW;
      out_last_r    <= 1'b1;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_heading        = out_heading_r;
  assign out_arc_length     = out_arc_r;
  assign out_curvature      = out_curv_r;
  assign out_curvature_rate = out_rate_r;
  assign out_status         = out_status_r;
  assign out_last_result    = out_last_r;

`ifndef SYNTHESIS
  // a last point always launches a run
  a_final_runs: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_final_point |=> busy) else $error("run not started");

  // iterative units are quiet whenever the engine is idle
  a_units_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> !div_act_r && !sq_act_r) else $error("unit active while idle");

  // divider never relaunched mid-operation
  a_div_launch: assert property (@(posedge clk) disable iff (!rst_n)
    div_go |-> !div_act_r) else $error("divider relaunched");

  // short path result is always the last of its run
  a_short_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_FEW |-> out_last_result) else $error("short not last");

  // point count never exceeds the memory depth
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_POINTS)) else $error("point count overflow");
`endif

endmodule
